// ----- design/tcd_pkg.sv -----
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared widths, controller states and command/status types for the
// trilinear charge deposit core.
// ----------------------------------------------------------------------------
package tcd_pkg;

    localparam int COORD_W       = 21;
    localparam int FRAC_BITS     = 16;
    localparam int IP_W          = COORD_W - FRAC_BITS;
    localparam int AXIS_W        = IP_W + 1;
    localparam int WGT_W         = FRAC_BITS + 1;
    localparam int CHARGE_W      = 32;
    localparam int CELL_W        = 48;
    localparam int PROD_W        = CHARGE_W + WGT_W + 1;
    localparam int ADD_W         = PROD_W - FRAC_BITS;
    localparam int SUM_W         = CELL_W + 1;
    localparam int CORNER_W      = 3;
    localparam int GRID_SIZE_DEF = 32;

    localparam logic [WGT_W-1:0]    ONE_W       = WGT_W'(1) << FRAC_BITS;
    localparam logic [CORNER_W-1:0] CORNER_LAST = '1;
    localparam logic [CELL_W-1:0]   CELL_MAX    = {1'b0, {(CELL_W-1){1'b1}}};
    localparam logic [CELL_W-1:0]   CELL_MIN    = {1'b1, {(CELL_W-1){1'b0}}};

    localparam logic MODE_DEPOSIT = 1'b0;
    localparam logic MODE_READ    = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RD_DATA,
        ST_W_XY,
        ST_W_XYZ,
        ST_MUL,
        ST_ACC,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic clear_we;
        logic take_item;
        logic rd_issue;
        logic w_xy;
        logic w_xyz;
        logic w_mul;
        logic acc;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic mode_read;
        logic item_oob;
        logic corner_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- design/tcd_if.sv -----
// ----------------------------------------------------------------------------
// tcd_req_if / tcd_rsp_if
// Valid/ready channels for deposit and read requests and for responses.
// ----------------------------------------------------------------------------
interface tcd_req_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [tcd_pkg::COORD_W-1:0]    x_coord;
    logic [tcd_pkg::COORD_W-1:0]    y_coord;
    logic [tcd_pkg::COORD_W-1:0]    z_coord;
    logic signed [tcd_pkg::CHARGE_W-1:0] charge_value;

    modport source (output valid, mode, x_coord, y_coord, z_coord, charge_value,
                    input ready);
    modport sink   (input valid, mode, x_coord, y_coord, z_coord, charge_value,
                    output ready);
endinterface

interface tcd_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [tcd_pkg::CELL_W-1:0]   cell_value;
    logic                                out_of_range;

    modport source (output valid, cell_value, out_of_range, input ready);
    modport sink   (input valid, cell_value, out_of_range, output ready);
endinterface

// ----- design/tcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcd_ctrl
// Sequencer for clearing, reads and the eight-corner deposit loop.
// ----------------------------------------------------------------------------
module tcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  tcd_pkg::t_dp_sts  i_sts,
    output tcd_pkg::t_dp_cmd  o_cmd
);

    tcd_pkg::t_state r_state;
    tcd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcd_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcd_pkg::ST_CLEAR: begin
                if (i_sts.clear_last) n_state = tcd_pkg::ST_IDLE;
            end
            tcd_pkg::ST_IDLE: begin
                if (i_req_valid) n_state = tcd_pkg::ST_DECODE;
            end
            tcd_pkg::ST_DECODE: begin
                if (i_sts.item_oob) begin
                    n_state = tcd_pkg::ST_RESULT;
                end else if (i_sts.mode_read) begin
                    n_state = tcd_pkg::ST_RD_DATA;
                end else begin
                    n_state = tcd_pkg::ST_W_XY;
                end
            end
            tcd_pkg::ST_RD_DATA: n_state = tcd_pkg::ST_RESULT;
            tcd_pkg::ST_W_XY:    n_state = tcd_pkg::ST_W_XYZ;
            tcd_pkg::ST_W_XYZ:   n_state = tcd_pkg::ST_MUL;
            tcd_pkg::ST_MUL:     n_state = tcd_pkg::ST_ACC;
            tcd_pkg::ST_ACC: begin
                n_state = i_sts.corner_last ? tcd_pkg::ST_IDLE : tcd_pkg::ST_W_XY;
            end
            tcd_pkg::ST_RESULT: begin
                if (i_sts.out_free) n_state = tcd_pkg::ST_IDLE;
            end
            default: n_state = tcd_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            tcd_pkg::ST_CLEAR: o_cmd.clear_we = 1'b1;
            tcd_pkg::ST_IDLE: begin
                o_req_ready     = 1'b1;
                o_cmd.take_item = i_req_valid;
            end
            tcd_pkg::ST_DECODE: begin
                o_cmd.rd_issue = i_sts.mode_read && !i_sts.item_oob;
            end
            tcd_pkg::ST_W_XY:   o_cmd.w_xy     = 1'b1;
            tcd_pkg::ST_W_XYZ:  o_cmd.w_xyz    = 1'b1;
            tcd_pkg::ST_MUL:    o_cmd.w_mul    = 1'b1;
            tcd_pkg::ST_ACC:    o_cmd.acc      = 1'b1;
            tcd_pkg::ST_RESULT: o_cmd.load_out = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- design/tcd_datapath.sv -----
// ----------------------------------------------------------------------------
// tcd_datapath
// Request registers, weight multipliers, grid memory and response register.
// ----------------------------------------------------------------------------
module tcd_datapath #(
    parameter int GRID_SIZE = tcd_pkg::GRID_SIZE_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tcd_pkg::t_dp_cmd                     i_cmd,
    output tcd_pkg::t_dp_sts                     o_sts,
    input  logic                                 i_mode,
    input  logic [tcd_pkg::COORD_W-1:0]          i_x_coord,
    input  logic [tcd_pkg::COORD_W-1:0]          i_y_coord,
    input  logic [tcd_pkg::COORD_W-1:0]          i_z_coord,
    input  logic signed [tcd_pkg::CHARGE_W-1:0]  i_charge_value,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [tcd_pkg::CELL_W-1:0]    o_cell_value,
    output logic                                 o_out_of_range
);

    localparam int CELLS  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int FB     = tcd_pkg::FRAC_BITS;
    localparam int WW     = tcd_pkg::WGT_W;

    // latched request
    logic                                r_mode;
    logic [tcd_pkg::IP_W-1:0]            r_ip_x, r_ip_y, r_ip_z;
    logic [FB-1:0]                       r_fx, r_fy, r_fz;
    logic signed [tcd_pkg::CHARGE_W-1:0] r_q;
    logic [tcd_pkg::CORNER_W-1:0]        r_corner;

    // weight chain
    logic [WW-1:0]                       r_wxy, r_wxyz;
    logic signed [tcd_pkg::ADD_W-1:0]    r_add;

    // grid memory and clear sweep
    logic [tcd_pkg::CELL_W-1:0]          mem [CELLS];
    logic [tcd_pkg::CELL_W-1:0]          r_rd_data;
    logic [ADDR_W-1:0]                   r_clr_addr;

    // response register
    logic                                r_out_valid;
    logic [tcd_pkg::CELL_W-1:0]          r_out_value;
    logic                                r_out_oob;

    logic [tcd_pkg::AXIS_W-1:0]          ax, ay, az;
    logic [ADDR_W-1:0]                   cell_addr;
    logic [WW-1:0]                       wx, wy, wz;
    logic [2*WW-1:0]                     p_xy, p_xyz;
    logic signed [tcd_pkg::PROD_W-1:0]   prod;
    logic signed [tcd_pkg::SUM_W-1:0]    sum;
    logic [tcd_pkg::CELL_W-1:0]          sat;
    logic                                dep_oob, rd_oob, item_oob;
    logic                                mem_we, mem_re;
    logic [ADDR_W-1:0]                   waddr;
    logic [tcd_pkg::CELL_W-1:0]          wdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_mode <= i_mode;
            r_ip_x <= i_x_coord[tcd_pkg::COORD_W-1:FB];
            r_ip_y <= i_y_coord[tcd_pkg::COORD_W-1:FB];
            r_ip_z <= i_z_coord[tcd_pkg::COORD_W-1:FB];
            r_fx   <= i_x_coord[FB-1:0];
            r_fy   <= i_y_coord[FB-1:0];
            r_fz   <= i_z_coord[FB-1:0];
            r_q    <= i_charge_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
        end else if (i_cmd.take_item) begin
            r_corner <= '0;
        end else if (i_cmd.acc) begin
            r_corner <= r_corner + tcd_pkg::CORNER_W'(1);
        end
    end

    // corner offsets: bit 0 steps x, bit 1 steps y, bit 2 steps z
    assign ax = tcd_pkg::AXIS_W'(r_ip_x) + tcd_pkg::AXIS_W'(r_corner[0]);
    assign ay = tcd_pkg::AXIS_W'(r_ip_y) + tcd_pkg::AXIS_W'(r_corner[1]);
    assign az = tcd_pkg::AXIS_W'(r_ip_z) + tcd_pkg::AXIS_W'(r_corner[2]);
    assign cell_addr = ADDR_W'(ax) + ADDR_W'(GRID_SIZE)
                     * (ADDR_W'(ay) + ADDR_W'(GRID_SIZE) * ADDR_W'(az));

    assign dep_oob = (32'(r_ip_x) > 32'(GRID_SIZE - 2)) || (32'(r_ip_y) > 32'(GRID_SIZE - 2))
                  || (32'(r_ip_z) > 32'(GRID_SIZE - 2));
    assign rd_oob  = (32'(r_ip_x) >= 32'(GRID_SIZE)) || (32'(r_ip_y) >= 32'(GRID_SIZE))
                  || (32'(r_ip_z) >= 32'(GRID_SIZE));
    assign item_oob = (r_mode == tcd_pkg::MODE_READ) ? rd_oob : dep_oob;

    // linear weights of the current corner
    assign wx = r_corner[0] ? WW'(r_fx) : tcd_pkg::ONE_W - WW'(r_fx);
    assign wy = r_corner[1] ? WW'(r_fy) : tcd_pkg::ONE_W - WW'(r_fy);
    assign wz = r_corner[2] ? WW'(r_fz) : tcd_pkg::ONE_W - WW'(r_fz);

    assign p_xy  = (2*WW)'(wx) * (2*WW)'(wy) + (2*WW)'(1 << (FB - 1));
    assign p_xyz = (2*WW)'(r_wxy) * (2*WW)'(wz) + (2*WW)'(1 << (FB - 1));
    assign prod  = tcd_pkg::PROD_W'(r_q) * tcd_pkg::PROD_W'($signed({1'b0, r_wxyz}))
                 + tcd_pkg::PROD_W'(1 << (FB - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.w_xy)  r_wxy  <= WW'(p_xy >> FB);
        if (i_cmd.w_xyz) r_wxyz <= WW'(p_xyz >> FB);
        if (i_cmd.w_mul) r_add  <= tcd_pkg::ADD_W'(prod >>> FB);
    end

    // saturating accumulate
    assign sum = tcd_pkg::SUM_W'($signed(r_rd_data)) + tcd_pkg::SUM_W'(r_add);
    always_comb begin
        if (sum[tcd_pkg::SUM_W-1] != sum[tcd_pkg::CELL_W-1]) begin
            sat = sum[tcd_pkg::SUM_W-1] ? tcd_pkg::CELL_MIN : tcd_pkg::CELL_MAX;
        end else begin
            sat = sum[tcd_pkg::CELL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_we) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    assign mem_we = i_cmd.clear_we || i_cmd.acc;
    assign mem_re = i_cmd.rd_issue || i_cmd.w_mul;
    assign waddr  = i_cmd.clear_we ? r_clr_addr : cell_addr;
    assign wdata  = i_cmd.clear_we ? '0 : sat;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[waddr] <= wdata;
        if (mem_re) r_rd_data <= mem[cell_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value <= item_oob ? '0 : r_rd_data;
            r_out_oob   <= item_oob;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cell_value   = $signed(r_out_value);
    assign o_out_of_range = r_out_oob;

    assign o_sts.clear_last  = (r_clr_addr == ADDR_W'(CELLS - 1));
    assign o_sts.mode_read   = (r_mode == tcd_pkg::MODE_READ);
    assign o_sts.item_oob    = item_oob;
    assign o_sts.corner_last = (r_corner == tcd_pkg::CORNER_LAST);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

endmodule

// ----- design/trilinear_charge_deposit_core.sv -----
// ----------------------------------------------------------------------------
// trilinear_charge_deposit_core
// Cloud-in-cell deposit of a weighted charge into a GRID_SIZE^3 grid of
// saturating 48-bit accumulators, plus single-cell reads.
// ----------------------------------------------------------------------------
// read: accept, decode, grid read, response register; no new request until loaded
// deposit: no response; accept and decode, then each of the eight corners in turn
//   through the two weight multipliers, the charge multiplier and the grid
// dropped deposit or read outside the grid: zero response with out_of_range set
// reset: a clearing pass writes zero into all GRID_SIZE^3 cells, one per
//   cycle, before the first request
module trilinear_charge_deposit_core #(
    parameter int GRID_SIZE = tcd_pkg::GRID_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcd_req_if.sink     i_req,
    tcd_rsp_if.source   o_rsp
);

    // command and status between sequencer and datapath
    tcd_pkg::t_dp_cmd cmd;
    tcd_pkg::t_dp_sts sts;

    // sequencer: clear sweep, request decode, corner loop, response hand-off
    tcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath: weights, multipliers, grid memory, response register
    tcd_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (i_req.mode),
        .i_x_coord      (i_req.x_coord),
        .i_y_coord      (i_req.y_coord),
        .i_z_coord      (i_req.z_coord),
        .i_charge_value (i_req.charge_value),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_cell_value   (o_rsp.cell_value),
        .o_out_of_range (o_rsp.out_of_range)
    );

endmodule
